// File: hdl/fm_iq_demodulator_decimator_macros.svh
// Assertion macros used by the checker file.
`ifndef FM_IQ_DEMODULATOR_DECIMATOR_MACROS_SVH
`define FM_IQ_DEMODULATOR_DECIMATOR_MACROS_SVH

// Antecedent implies consequent on the next clock.
`define FMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same clock.
`define FMD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/fmd_pkg.sv
`timescale 1ns / 1ps
package fmd_pkg;

  // Fixed filter and front-end configuration
  localparam int TAPS        = 81;
  localparam int DECIM       = 20;
  localparam int SAMPLE_RATE = 960000;
  localparam int CUTOFF_HZ   = 15000;
  localparam int DC_SHIFT    = 11;

  localparam int CORDIC_STEPS = 23;
  localparam int VEC_STEPS    = 16;
  localparam longint QUARTER_TURN = 64'sd4194304;
  localparam longint TWO_PI_Q30   = 64'sd6746518852;
  localparam longint INV_GAIN_Q30 = 64'sd652032875;
  localparam longint ACC_LIMIT    = 64'sd8589934592;
  localparam longint AUDIO_K =
    (longint'(SAMPLE_RATE) * 32767 * 256 + 37500) / 75000;

  // Datapath widths
  localparam int IDX_W  = $clog2(TAPS);
  localparam int FILL_W = $clog2(TAPS + 1);
  localparam int CNT_W  = $clog2(DECIM + 1);
  localparam int STEP_W = $clog2(VEC_STEPS);
  localparam int DC_W   = 8 + DC_SHIFT + 3;
  localparam int S_W    = 11;
  localparam int P_W    = 23;
  localparam int X_W    = 32;
  localparam int Z_W    = 26;
  localparam int PH_W   = 16;
  localparam int TAP_W  = 18;
  localparam int ACC_W  = 42;
  localparam int AC_W   = 35;
  localparam int K_W    = 28;
  localparam int M_W    = 47;
  localparam int N_W    = 63;
  localparam int AU_W   = 28;

  // atan(2^-i), unit 2^-24 turn
  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
  };

  typedef logic signed [TAP_W-1:0] tap_arr_t [TAPS];

  typedef struct packed {
    longint s;
    longint c;
  } sc_t;

  // Restoring division of a non-negative value by a positive one
  function automatic longint udiv(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((n >>> i) & 1);
      q = q <<< 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Rotation-mode CORDIC, Q30 sine and cosine of a 2^-24 turn angle
  function automatic sc_t sin_cos(longint ph);
    longint quad;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    sc_t r;
    quad = (ph >> 22) & 3;
    z = ph & (QUARTER_TURN - 1);
    x = INV_GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_TAB[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_TAB[i];
      end
    end
    case (quad)
      0: begin r.s = y;  r.c = x;  end
      1: begin r.s = x;  r.c = -y; end
      2: begin r.s = -y; r.c = -x; end
      default: begin r.s = -x; r.c = y; end
    endcase
    return r;
  endfunction

  // Hamming-windowed sinc, normalized to unity DC gain, Q1.17
  function automatic tap_arr_t build_taps();
    longint prod [TAPS];
    longint sum;
    longint am;
    longint v;
    longint w;
    longint ph;
    longint num;
    int m;
    sc_t sc;
    tap_arr_t r;
    sum = 0;
    for (int n = 0; n < TAPS; n++) begin
      m = n - (TAPS - 1) / 2;
      am = (m < 0) ? -m : m;
      if (m == 0) begin
        v = TWO_PI_Q30 * CUTOFF_HZ / SAMPLE_RATE;
      end else begin
        ph = ((longint'(CUTOFF_HZ) * am * 16777216 + SAMPLE_RATE / 2) / SAMPLE_RATE)
             & 64'hFFFFFF;
        sc = sin_cos(ph);
        v = (sc.s >= 0) ? udiv(sc.s + am / 2, am) : -udiv(-sc.s + am / 2, am);
      end
      ph = ((longint'(n) * 16777216 + (TAPS - 1) / 2) / (TAPS - 1)) & 64'hFFFFFF;
      sc = sin_cos(ph);
      num = 54 * 64'sd1073741824 - 46 * sc.c;
      w = (num >= 0) ? (num + 50) / 100 : -((-num + 50) / 100);
      prod[n] = (v * w) >>> 30;
      sum = sum + prod[n];
    end
    if (sum <= 0) sum = 1;
    for (int n = 0; n < TAPS; n++) begin
      num = prod[n] * 131072;
      v = (num >= 0) ? udiv(num + sum / 2, sum) : -udiv(-num + sum / 2, sum);
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      r[n] = TAP_W'(v);
    end
    return r;
  endfunction

  localparam tap_arr_t TAP_ROM = build_taps();

  // Controller to datapath commands
  typedef struct packed {
    logic              dc_en;
    logic              mul_en;
    logic              pre_en;
    logic              cord_en;
    logic [STEP_W-1:0] cord_step;
    logic              hist_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic              mac_clr;
    logic              mac_en;
    logic              mac_zero;
    logic [IDX_W-1:0]  tap_idx;
    logic              clamp_en;
    logic              scl_lo;
    logic              scl_hi;
    logic              round_en;
    logic              dm1_en;
    logic              dm2_en;
    logic              vol_en;
    logic              out_load;
  } fmd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic deemph_on;
  } fmd_stat_t;

endpackage

// File: hdl/fmd_ram.sv
`timescale 1ns / 1ps
module fmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/fmd_datapath.sv
`timescale 1ns / 1ps
module fmd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       s_axis_tdata,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  fmd_pkg::fmd_cmd_t cmd,
  output fmd_pkg::fmd_stat_t stat,
  output logic [15:0]       audio_sample
);
  import fmd_pkg::*;

  localparam logic cfg_deemph = 1'b0;
  localparam logic cfg_volume = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(ACC_LIMIT);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(ACC_LIMIT);
  localparam logic signed [K_W-1:0]   K_SC   = K_W'(AUDIO_K);
  localparam logic signed [44:0] Y_HI = 45'sd32767 * 45'sd65536;
  localparam logic signed [44:0] Y_LO = -45'sd32768 * 45'sd65536;

  logic [15:0] deemph_coeff;
  logic [15:0] volume_gain;
  logic signed [DC_W-1:0] dc_i, dc_q, dc_i_next, dc_q_next;
  logic signed [S_W-1:0] si, sq, lci, lcq, si_next, sq_next;
  logic signed [9:0] ri, rq;
  logic signed [P_W-1:0] re, im;
  logic signed [X_W-1:0] x, y, sx, sy;
  logic signed [Z_W-1:0] z;
  logic zero_vec;
  logic [PH_W-1:0] phase;
  logic [PH_W-1:0] hist_rd;
  logic signed [TAP_W+PH_W-1:0] mac_prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [AC_W-1:0] accc;
  logic signed [18:0] m_a;
  logic signed [M_W-1:0] m_p, p_lo, p_hi;
  logic signed [N_W-1:0] n_sum, n_rnd;
  logic signed [AU_W-1:0] audio, level, level_next;
  logic signed [45:0] dprod;
  logic signed [44:0] yv;
  logic [15:0] res;

  assign stat.deemph_on = (deemph_coeff != '0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deemph_coeff <= 16'd19275;
      volume_gain  <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        cfg_deemph: deemph_coeff <= cfg_data;
        cfg_volume: volume_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // DC removal straight from the accepted item
  always_comb begin
    ri = signed'({1'b0, s_axis_tdata[7:0], 1'b0}) - 10'sd255;
    rq = signed'({1'b0, s_axis_tdata[15:8], 1'b0}) - 10'sd255;
    dc_i_next = dc_i + DC_W'(ri) - (dc_i >>> DC_SHIFT);
    dc_q_next = dc_q + DC_W'(rq) - (dc_q >>> DC_SHIFT);
    si_next = S_W'(ri) - S_W'(dc_i_next >>> DC_SHIFT);
    sq_next = S_W'(rq) - S_W'(dc_q_next >>> DC_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_i <= '0;
      dc_q <= '0;
      lci  <= '0;
      lcq  <= '0;
    end else begin
      if (cmd.dc_en) begin
        dc_i <= dc_i_next;
        dc_q <= dc_q_next;
      end
      if (cmd.mul_en) begin
        lci <= si;
        lcq <= sq;
      end
    end
  end

  // Corrected sample and conjugate product with the previous one
  always_ff @(posedge clk) begin
    if (cmd.dc_en) begin
      si <= si_next;
      sq <= sq_next;
    end
    if (cmd.mul_en) begin
      re <= P_W'(si) * P_W'(lci) + P_W'(sq) * P_W'(lcq);
      im <= P_W'(sq) * P_W'(lci) - P_W'(si) * P_W'(lcq);
    end
  end

  // Vectoring CORDIC, one micro-rotation per cycle
  assign sx = x >>> cmd.cord_step;
  assign sy = y >>> cmd.cord_step;

  always_ff @(posedge clk) begin
    if (cmd.pre_en) begin
      zero_vec <= (re == '0) && (im == '0);
      if (re < 0) begin
        if (im >= 0) begin
          x <= X_W'(im) <<< 8;
          y <= -(X_W'(re) <<< 8);
          z <= Z_W'(QUARTER_TURN);
        end else begin
          x <= -(X_W'(im) <<< 8);
          y <= X_W'(re) <<< 8;
          z <= -Z_W'(QUARTER_TURN);
        end
      end else begin
        x <= X_W'(re) <<< 8;
        y <= X_W'(im) <<< 8;
        z <= '0;
      end
    end else if (cmd.cord_en) begin
      if (y >= 0) begin
        x <= x + sy;
        y <= y - sx;
        z <= z + Z_W'(ATAN_TAB[cmd.cord_step]);
      end else begin
        x <= x - sy;
        y <= y + sx;
        z <= z - Z_W'(ATAN_TAB[cmd.cord_step]);
      end
    end
  end

  // Round 2^-24 turn to 2^-16 turn, wrapping
  always_comb begin
    phase = PH_W'((z + Z_W'(128)) >>> 8);
    if (zero_vec) phase = '0;
  end

  fmd_ram #(.WIDTH(PH_W), .DEPTH(TAPS)) u_hist (
    .clk   (clk),
    .we    (cmd.hist_we),
    .waddr (cmd.wr_addr),
    .wdata (phase),
    .raddr (cmd.rd_addr),
    .rdata (hist_rd)
  );

  // FIR multiply-accumulate, never-written slots read as zero
  always_comb begin
    mac_prod = TAP_ROM[cmd.tap_idx] * signed'(hist_rd);
    if (cmd.mac_zero) mac_prod = '0;
  end

  // Shared scaling multiplier: low then high half of the clamped sum
  assign m_a = cmd.scl_hi ? 19'(signed'(accc[AC_W-1:17])) : signed'({2'b00, accc[16:0]});
  assign m_p = M_W'(m_a) * M_W'(K_SC);

  assign n_sum = (N_W'(p_hi) <<< 17) + N_W'(p_lo);
  assign n_rnd = n_sum + N_W'(64'sd4294967296) - N_W'(n_sum < 0);

  assign level_next = level + AU_W'(dprod >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) acc <= '0;
    else if (cmd.mac_en) acc <= acc + ACC_W'(mac_prod);
    if (cmd.clamp_en) begin
      if (acc > ACC_HI) accc <= AC_W'(ACC_HI);
      else if (acc < ACC_LO) accc <= AC_W'(ACC_LO);
      else accc <= AC_W'(acc);
    end
    if (cmd.scl_lo) p_lo <= m_p;
    if (cmd.scl_hi) p_hi <= m_p;
    if (cmd.round_en) audio <= AU_W'(n_rnd >>> 33);
    else if (cmd.dm2_en) audio <= level_next;
    if (cmd.dm1_en) dprod <= 46'(signed'({1'b0, deemph_coeff})) *
                             46'(29'(audio) - 29'(level));
    if (cmd.vol_en) yv <= 45'(audio) * 45'(signed'({1'b0, volume_gain}));
  end

  always_ff @(posedge clk) begin
    if (rst) level <= '0;
    else if (cmd.dm2_en) level <= level_next;
  end

  // Saturate, then truncate toward zero
  always_comb begin
    if (yv >= Y_HI) res = 16'h7FFF;
    else if (yv <= Y_LO) res = 16'h8000;
    else res = 16'((yv + ((yv < 0) ? 45'sd65535 : 45'sd0)) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) audio_sample <= res;
  end

endmodule

// File: hdl/fmd_ctrl.sv
`timescale 1ns / 1ps
module fmd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  fmd_pkg::fmd_stat_t stat,
  output fmd_pkg::fmd_cmd_t  cmd
);
  import fmd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_PRE   = 4'd2;
  localparam logic [3:0] ST_CORD  = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_FIR   = 4'd5;
  localparam logic [3:0] ST_CLAMP = 4'd6;
  localparam logic [3:0] ST_SCLLO = 4'd7;
  localparam logic [3:0] ST_SCLHI = 4'd8;
  localparam logic [3:0] ST_ROUND = 4'd9;
  localparam logic [3:0] ST_DM1   = 4'd10;
  localparam logic [3:0] ST_DM2   = 4'd11;
  localparam logic [3:0] ST_VOL   = 4'd12;
  localparam logic [3:0] ST_SAT   = 4'd13;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TAPS - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(TAPS);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(DECIM - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VEC_STEPS - 1);

  logic [3:0] state, state_next;
  logic have_last;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0] ptr, ptr_inc, rd_idx;
  logic [FILL_W-1:0] fill, tcnt;
  logic [CNT_W-1:0] cnt;
  logic rd_valid_d, zero_d;
  logic [IDX_W-1:0] tap_d;
  logic out_valid;
  logic accept, issue, out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign out_free = !out_valid || m_axis_tready;
  assign issue    = (state == ST_FIR) && (tcnt != FULL);
  assign ptr_inc  = (ptr == LAST_IDX) ? '0 : ptr + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_MUL;
      ST_MUL:   state_next = have_last ? ST_PRE : ST_IDLE;
      ST_PRE:   state_next = ST_CORD;
      ST_CORD:  if (step == LAST_STEP) state_next = ST_WR;
      ST_WR:    state_next = (cnt == LAST_CNT) ? ST_FIR : ST_IDLE;
      ST_FIR:   if (tcnt == FULL) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_SCLLO;
      ST_SCLLO: state_next = ST_SCLHI;
      ST_SCLHI: state_next = ST_ROUND;
      ST_ROUND: state_next = stat.deemph_on ? ST_DM1 : ST_VOL;
      ST_DM1:   state_next = ST_DM2;
      ST_DM2:   state_next = ST_VOL;
      ST_VOL:   state_next = ST_SAT;
      ST_SAT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      have_last  <= 1'b0;
      step       <= '0;
      ptr        <= '0;
      fill       <= '0;
      cnt        <= '0;
      tcnt       <= '0;
      rd_idx     <= '0;
      rd_valid_d <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) have_last <= 1'b1;
      if (state == ST_PRE) step <= '0;
      else if (state == ST_CORD) step <= step + 1'b1;
      if (state == ST_WR) begin
        ptr <= ptr_inc;
        if (fill != FULL) fill <= fill + 1'b1;
        cnt <= (cnt == LAST_CNT) ? '0 : cnt + 1'b1;
        tcnt <= '0;
        rd_idx <= ptr_inc;
      end else if (issue) begin
        tcnt <= tcnt + 1'b1;
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end
      rd_valid_d <= issue;
      if (state == ST_SAT && out_free) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // Tap index and fill check follow the registered history read
  always_ff @(posedge clk) begin
    tap_d  <= tcnt[IDX_W-1:0];
    zero_d <= !(FILL_W'(rd_idx) < fill);
  end

  always_comb begin
    cmd.dc_en     = accept;
    cmd.mul_en    = (state == ST_MUL);
    cmd.pre_en    = (state == ST_PRE);
    cmd.cord_en   = (state == ST_CORD);
    cmd.cord_step = step;
    cmd.hist_we   = (state == ST_WR);
    cmd.wr_addr   = ptr;
    cmd.rd_addr   = rd_idx;
    cmd.mac_clr   = (state == ST_WR);
    cmd.mac_en    = rd_valid_d;
    cmd.mac_zero  = zero_d;
    cmd.tap_idx   = tap_d;
    cmd.clamp_en  = (state == ST_CLAMP);
    cmd.scl_lo    = (state == ST_SCLLO);
    cmd.scl_hi    = (state == ST_SCLHI);
    cmd.round_en  = (state == ST_ROUND);
    cmd.dm1_en    = (state == ST_DM1);
    cmd.dm2_en    = (state == ST_DM2);
    cmd.vol_en    = (state == ST_VOL);
    cmd.out_load  = (state == ST_SAT) && out_free;
  end

endmodule

// File: hdl/fm_iq_demodulator_decimator.sv
`timescale 1ns / 1ps
// Channel  Dir  Width  Contents
// s_axis   in   16     i_sample [7:0], q_sample [15:8]
// m_axis   out  16     audio_sample [15:0]
// cfg      in   1+16   0 deemph_coeff, 1 volume_gain
//
// Each item is accepted, then runs the conjugate product, pre-rotation,
// 16 CORDIC micro-rotations and the history write; the very first item
// stops after the product. Every 20th phase adds the FIR MAC (one history
// RAM read per tap), scaling, optional de-emphasis, gain and saturation.
// Synchronous active-high reset; the history reads as zero until written.
// A result waiting on m_axis holds only the final saturation step.
module fm_iq_demodulator_decimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // i_sample [7:0], q_sample [15:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // audio_sample [15:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import fmd_pkg::*;

  fmd_cmd_t  cmd;
  fmd_stat_t stat;

  fmd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  fmd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .audio_sample (m_axis_tdata)
  );

endmodule

// File: hdl/fmd_checker.sv
`timescale 1ns / 1ps
`include "fm_iq_demodulator_decimator_macros.svh"
module fmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Reset leaves the block ready with no result pending
  `FMD_ASSERT_NEXT(a_reset, clk, 1'b0, rst, s_axis_tready && !m_axis_tvalid, "bad reset state")

  // An accepted item keeps the block busy on the next cycle
  `FMD_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "not busy")

  // A new result is only issued while no item is being taken
  `FMD_ASSERT_SAME(a_issue, clk, rst, $rose(m_axis_tvalid), !$past(s_axis_tready), "bad issue")

  // A stalled result holds
  `FMD_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind fm_iq_demodulator_decimator fmd_checker u_fmd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
